@@ hdl/rpsr_pkg.sv @@
// rpsr_pkg: shared widths, register indexes, constants and stage payload types
// for the rotated point splat renderer. No dependencies; every other file uses it.
`default_nettype none

package rpsr_pkg;

  // default coordinate width of the pixel grid
  localparam int COORD_BITS_DEF = 20;

  // field widths
  localparam int SHEET_W   = 28;
  localparam int TRIG_W    = 16;
  localparam int TRIG_FRAC = 14;
  localparam int VOL_W     = 16;
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 21;
  localparam int BOX_W     = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 28;

  // transform arithmetic
  localparam int PROD_W    = SHEET_W + TRIG_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int FRAC_BITS = 22;
  localparam int RND_W     = SUM_W - FRAC_BITS + 1;
  localparam int EXT_W     = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RENDER_PASS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_ONLY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COS_Q       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_Q       = 3'd5;

  localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;

  // plane bands: a coordinate is split into (coord >> 3) and the low 3 bits,
  // so coord % 200 < 8 means (coord >> 3) % 25 == 0, and % 600 means % 75
  localparam int BAND_SHIFT     = 3;
  localparam int BAND_W         = VOL_W - BAND_SHIFT;
  localparam int RECIP75_SHIFT  = 19;
  localparam int Q75_W          = 7;
  localparam int MOD_W          = 7;
  localparam logic [BAND_W-1:0] RECIP75  = 13'd6991;
  localparam logic [BAND_W-1:0] BAND_MOD = 13'd75;
  // residues of (coord >> 3) % 75 that lie on a 200 band
  localparam logic [MOD_W-1:0] PHASE_RED   = 7'd0;
  localparam logic [MOD_W-1:0] PHASE_MID   = 7'd25;
  localparam logic [MOD_W-1:0] PHASE_GREEN = 7'd50;

  localparam logic [VOL_W-1:0] GLOW_LO = 16'd5000;
  localparam logic [VOL_W-1:0] GLOW_HI = 16'd5008;

  localparam int TINT_W = 7;
  localparam logic [TINT_W-1:0] TINT_STRONG = 7'd64;
  localparam logic [TINT_W-1:0] TINT_WEAK   = 7'd32;
  localparam logic [CHAN_W-1:0] CHAN_MAX    = 8'd255;

  // 3x3 neighbourhood walk
  localparam int NB_W = 2;
  localparam logic [NB_W-1:0] NB_LAST = 2'd2;

  typedef struct packed {
    logic                      render_pass;
    logic                      mask_only;
    logic signed [SHEET_W-1:0] offset_x;
    logic signed [SHEET_W-1:0] offset_y;
    logic signed [TRIG_W-1:0]  cos_q;
    logic signed [TRIG_W-1:0]  sin_q;
  } cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] xc;
    logic signed [PROD_W-1:0] ys;
    logic signed [PROD_W-1:0] yc;
    logic signed [PROD_W-1:0] xs;
    rgb_t                     scaled;
    logic [BAND_W-1:0]        z_band;
    logic [BAND_W-1:0]        x_band;
    logic [Q75_W-1:0]         z_q75;
    logic [Q75_W-1:0]         x_q75;
    logic                     z_glow;
  } prod_t;

  // saturate a sign-extended value to a signed range of the given width
  function automatic logic signed [EXT_W-1:0] sat_ext(input logic signed [EXT_W-1:0] v,
                                                      input int bits);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    hi = (EXT_W'(1) <<< (bits - 1)) - EXT_W'(1);
    lo = -hi - EXT_W'(1);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rpsr_front.sv @@
// rpsr_front: input register, rotation products and colour scaling.
// Registers one point, then four 28x16 products, colour*value/255 and band quotients.
// Uses rpsr_pkg.
`default_nettype none

module rpsr_front (
  input  logic                                clk,
  input  logic                                rst,
  input  rpsr_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [rpsr_pkg::SHEET_W-1:0] sheet_x,
  input  logic signed [rpsr_pkg::SHEET_W-1:0] sheet_y,
  input  logic [rpsr_pkg::VOL_W-1:0]          vol_x,
  input  logic [rpsr_pkg::VOL_W-1:0]          vol_z,
  input  logic [rpsr_pkg::VOL_W-1:0]          voxel,
  input  logic [rpsr_pkg::CHAN_W-1:0]         red,
  input  logic [rpsr_pkg::CHAN_W-1:0]         green,
  input  logic [rpsr_pkg::CHAN_W-1:0]         blue,
  output logic                                prod_valid,
  input  logic                                prod_ready,
  output rpsr_pkg::prod_t                     prod
);

  localparam int MUL_W = 2 * rpsr_pkg::CHAN_W;
  localparam int RQ_W  = 2 * rpsr_pkg::BAND_W;

  logic                                s1_valid;
  logic signed [rpsr_pkg::SHEET_W-1:0] s1_sheet_x;
  logic signed [rpsr_pkg::SHEET_W-1:0] s1_sheet_y;
  logic [rpsr_pkg::VOL_W-1:0]          s1_vol_x;
  logic [rpsr_pkg::VOL_W-1:0]          s1_vol_z;
  logic [rpsr_pkg::VOL_W-1:0]          s1_voxel;
  logic [rpsr_pkg::CHAN_W-1:0]         s1_red;
  logic [rpsr_pkg::CHAN_W-1:0]         s1_green;
  logic [rpsr_pkg::CHAN_W-1:0]         s1_blue;

  logic                                advance;
  logic [rpsr_pkg::CHAN_W-1:0]         value;
  logic [rpsr_pkg::BAND_W-1:0]         z_band;
  logic [rpsr_pkg::BAND_W-1:0]         x_band;
  logic [RQ_W-1:0]                     z_recip;
  logic [RQ_W-1:0]                     x_recip;
  rpsr_pkg::prod_t                     prod_next;

  // x / 255 for x up to 255*255
  function automatic logic [rpsr_pkg::CHAN_W-1:0] div255(input logic [MUL_W-1:0] x);
    logic [MUL_W:0] acc;
    acc = (MUL_W + 1)'(x) + (MUL_W + 1)'(x >> rpsr_pkg::CHAN_W) + (MUL_W + 1)'(1);
    return acc[MUL_W-1:rpsr_pkg::CHAN_W];
  endfunction

  assign advance  = s1_valid && (!prod_valid || prod_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sheet_x <= sheet_x;
      s1_sheet_y <= sheet_y;
      s1_vol_x   <= vol_x;
      s1_vol_z   <= vol_z;
      s1_voxel   <= voxel;
      s1_red     <= red;
      s1_green   <= green;
      s1_blue    <= blue;
    end
  end

  assign value  = s1_voxel[rpsr_pkg::VOL_W-1 -: rpsr_pkg::CHAN_W];
  assign z_band = s1_vol_z[rpsr_pkg::VOL_W-1:rpsr_pkg::BAND_SHIFT];
  assign x_band = s1_vol_x[rpsr_pkg::VOL_W-1:rpsr_pkg::BAND_SHIFT];
  assign z_recip = RQ_W'(z_band) * RQ_W'(rpsr_pkg::RECIP75);
  assign x_recip = RQ_W'(x_band) * RQ_W'(rpsr_pkg::RECIP75);

  always_comb begin
    prod_next.xc = rpsr_pkg::PROD_W'(s1_sheet_x) * rpsr_pkg::PROD_W'(cfg.cos_q);
    prod_next.ys = rpsr_pkg::PROD_W'(s1_sheet_y) * rpsr_pkg::PROD_W'(cfg.sin_q);
    prod_next.yc = rpsr_pkg::PROD_W'(s1_sheet_y) * rpsr_pkg::PROD_W'(cfg.cos_q);
    prod_next.xs = rpsr_pkg::PROD_W'(s1_sheet_x) * rpsr_pkg::PROD_W'(cfg.sin_q);
    prod_next.scaled.red   = div255(MUL_W'(s1_red) * MUL_W'(value));
    prod_next.scaled.green = div255(MUL_W'(s1_green) * MUL_W'(value));
    prod_next.scaled.blue  = div255(MUL_W'(s1_blue) * MUL_W'(value));
    prod_next.z_band = z_band;
    prod_next.x_band = x_band;
    prod_next.z_q75  = z_recip[rpsr_pkg::RECIP75_SHIFT +: rpsr_pkg::Q75_W];
    prod_next.x_q75  = x_recip[rpsr_pkg::RECIP75_SHIFT +: rpsr_pkg::Q75_W];
    prod_next.z_glow = (s1_vol_z >= rpsr_pkg::GLOW_LO) && (s1_vol_z <= rpsr_pkg::GLOW_HI);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (advance) begin
      prod_valid <= 1'b1;
    end else if (prod_ready) begin
      prod_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod <= prod_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rpsr_point.sv @@
// rpsr_point: sums the rotation products, rounds and saturates the pixel position,
// and finishes the colour with plane tints and clamping. Uses rpsr_pkg.
`default_nettype none

module rpsr_point #(
  parameter int COORD_BITS = rpsr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rpsr_pkg::cfg_t               cfg,
  input  logic                         prod_valid,
  output logic                         prod_ready,
  input  rpsr_pkg::prod_t              prod,
  output logic                         pt_valid,
  input  logic                         pt_ready,
  output logic signed [COORD_BITS-1:0] pt_x,
  output logic signed [COORD_BITS-1:0] pt_y,
  output rpsr_pkg::rgb_t               pt_rgb
);

  localparam int SUM_W = rpsr_pkg::SUM_W;
  localparam int RND_W = rpsr_pkg::RND_W;
  localparam int EXT_W = rpsr_pkg::EXT_W;
  localparam int ACC_W = rpsr_pkg::CHAN_W + 2;

  logic                        advance;
  logic signed [SUM_W-1:0]     s_sum;
  logic signed [SUM_W-1:0]     t_sum;
  logic [rpsr_pkg::BAND_W-1:0] z_mod_full;
  logic [rpsr_pkg::BAND_W-1:0] x_mod_full;
  logic [rpsr_pkg::MOD_W-1:0]  z_mod;
  logic [rpsr_pkg::MOD_W-1:0]  x_mod;
  logic                        z_band_hit;
  logic                        x_band_hit;
  logic [rpsr_pkg::TINT_W-1:0] add_r;
  logic [rpsr_pkg::TINT_W-1:0] add_g;
  logic [rpsr_pkg::TINT_W-1:0] add_b;
  rpsr_pkg::rgb_t              rgb_next;

  // round half up for positive, toward zero for negative, then saturate
  function automatic logic signed [COORD_BITS-1:0] round_sat(input logic signed [SUM_W-1:0] v);
    logic signed [RND_W-1:0] whole;
    logic                    bump;
    logic signed [RND_W-1:0] r;
    logic signed [EXT_W-1:0] e;
    whole = RND_W'(v >>> rpsr_pkg::FRAC_BITS);
    bump  = v[SUM_W-1] ? (|v[rpsr_pkg::FRAC_BITS-1:0]) : v[rpsr_pkg::FRAC_BITS-1];
    r     = whole + RND_W'(bump);
    e     = rpsr_pkg::sat_ext(EXT_W'(r), COORD_BITS);
    return e[COORD_BITS-1:0];
  endfunction

  function automatic logic [rpsr_pkg::CHAN_W-1:0] tint(input logic [rpsr_pkg::CHAN_W-1:0] base,
                                                       input logic [rpsr_pkg::TINT_W-1:0] add,
                                                       input logic                      dark);
    logic signed [ACC_W-1:0] acc;
    acc = signed'(ACC_W'(base)) + signed'(ACC_W'(add))
        - (dark ? signed'(ACC_W'(rpsr_pkg::TINT_STRONG)) : signed'(ACC_W'(0)));
    if (acc < 0) begin
      return '0;
    end else if (acc > signed'(ACC_W'(rpsr_pkg::CHAN_MAX))) begin
      return rpsr_pkg::CHAN_MAX;
    end
    return acc[rpsr_pkg::CHAN_W-1:0];
  endfunction

  assign prod_ready = !pt_valid || pt_ready;
  assign advance    = prod_valid && prod_ready;

  assign s_sum = SUM_W'(prod.xc) + SUM_W'(prod.ys)
               + (SUM_W'(cfg.offset_x) <<< rpsr_pkg::TRIG_FRAC);
  assign t_sum = SUM_W'(prod.yc) - SUM_W'(prod.xs)
               + (SUM_W'(cfg.offset_y) <<< rpsr_pkg::TRIG_FRAC);

  // remainder of (coord >> 3) by 75 from the registered quotient
  assign z_mod_full = prod.z_band - rpsr_pkg::BAND_W'(prod.z_q75) * rpsr_pkg::BAND_MOD;
  assign x_mod_full = prod.x_band - rpsr_pkg::BAND_W'(prod.x_q75) * rpsr_pkg::BAND_MOD;
  assign z_mod = z_mod_full[rpsr_pkg::MOD_W-1:0];
  assign x_mod = x_mod_full[rpsr_pkg::MOD_W-1:0];

  assign z_band_hit = (z_mod == rpsr_pkg::PHASE_RED) || (z_mod == rpsr_pkg::PHASE_MID) ||
                      (z_mod == rpsr_pkg::PHASE_GREEN);
  assign x_band_hit = (x_mod == rpsr_pkg::PHASE_RED) || (x_mod == rpsr_pkg::PHASE_MID) ||
                      (x_mod == rpsr_pkg::PHASE_GREEN);

  always_comb begin
    add_r = '0;
    add_g = '0;
    add_b = '0;
    if (prod.z_glow) begin
      add_r = rpsr_pkg::TINT_STRONG;
      add_g = rpsr_pkg::TINT_STRONG;
      add_b = rpsr_pkg::TINT_STRONG;
    end else if (z_band_hit) begin
      add_r = (z_mod == rpsr_pkg::PHASE_RED) ? rpsr_pkg::TINT_STRONG : rpsr_pkg::TINT_WEAK;
      add_g = (z_mod == rpsr_pkg::PHASE_GREEN) ? rpsr_pkg::TINT_STRONG : rpsr_pkg::TINT_WEAK;
      add_b = rpsr_pkg::TINT_STRONG;
    end
    if (cfg.mask_only) begin
      rgb_next.red   = rpsr_pkg::CHAN_MAX;
      rgb_next.green = rpsr_pkg::CHAN_MAX;
      rgb_next.blue  = rpsr_pkg::CHAN_MAX;
    end else begin
      rgb_next.red   = tint(prod.scaled.red, add_r, x_band_hit);
      rgb_next.green = tint(prod.scaled.green, add_g, x_band_hit);
      rgb_next.blue  = tint(prod.scaled.blue, add_b, x_band_hit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
    end else if (advance) begin
      pt_valid <= 1'b1;
    end else if (pt_ready) begin
      pt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pt_x   <= round_sat(s_sum);
      pt_y   <= round_sat(t_sum);
      pt_rgb <= rgb_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rpsr_emit.sv @@
// rpsr_emit: bounding box state, 3x3 neighbourhood walk and the result register.
// Tracks the box or emits one pixel per cycle while out_ready allows. Uses rpsr_pkg.
`default_nettype none

module rpsr_emit #(
  parameter int COORD_BITS = rpsr_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rpsr_pkg::cfg_t                    cfg,
  input  logic                              pt_valid,
  output logic                              pt_ready,
  input  logic signed [COORD_BITS-1:0]      pt_x,
  input  logic signed [COORD_BITS-1:0]      pt_y,
  input  rpsr_pkg::rgb_t                    pt_rgb,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rpsr_pkg::PIX_W-1:0]        pixel_col,
  output logic [rpsr_pkg::PIX_W-1:0]        pixel_row,
  output rpsr_pkg::rgb_t                    out_rgb,
  output logic                              outside_sheet,
  output logic                              last_of_point,
  output logic [rpsr_pkg::BOX_W-1:0]        box_min_x,
  output logic [rpsr_pkg::BOX_W-1:0]        box_min_y,
  output logic [rpsr_pkg::PIX_W-1:0]        sheet_width,
  output logic [rpsr_pkg::PIX_W-1:0]        sheet_height
);

  localparam int EXT_W = rpsr_pkg::EXT_W;
  localparam int CW    = COORD_BITS + 1;

  logic [rpsr_pkg::NB_W-1:0]    ci;
  logic [rpsr_pkg::NB_W-1:0]    cj;
  logic signed [COORD_BITS-1:0] lo_x;
  logic signed [COORD_BITS-1:0] hi_x;
  logic signed [COORD_BITS-1:0] lo_y;
  logic signed [COORD_BITS-1:0] hi_y;
  logic                         box_empty;

  logic                         load;
  logic                         last_nb;
  logic                         emit;
  logic                         track;
  logic signed [EXT_W-1:0]      dx;
  logic signed [EXT_W-1:0]      dy;
  logic signed [EXT_W-1:0]      d;
  logic signed [EXT_W-1:0]      nb_x_ext;
  logic signed [EXT_W-1:0]      nb_y_ext;
  logic signed [EXT_W-1:0]      hx_ext;
  logic signed [EXT_W-1:0]      lx_ext;
  logic signed [EXT_W-1:0]      hy_ext;
  logic signed [EXT_W-1:0]      ly_ext;
  logic signed [COORD_BITS-1:0] nb_x;
  logic signed [COORD_BITS-1:0] nb_y;
  logic signed [COORD_BITS-1:0] cand_hi_x;
  logic signed [COORD_BITS-1:0] cand_lo_x;
  logic signed [COORD_BITS-1:0] cand_hi_y;
  logic signed [COORD_BITS-1:0] cand_lo_y;
  logic signed [CW-1:0]         col;
  logic signed [CW-1:0]         row;
  logic [CW-1:0]                w;
  logic [CW-1:0]                h;
  logic                         outside;
  logic signed [EXT_W-1:0]      col_ext;
  logic signed [EXT_W-1:0]      row_ext;
  logic [EXT_W-1:0]             w_ext;
  logic [EXT_W-1:0]             h_ext;
  logic signed [EXT_W-1:0]      lo_x_ext;
  logic signed [EXT_W-1:0]      lo_y_ext;

  assign load    = !out_valid || out_ready;
  assign last_nb = !cfg.mask_only || ((ci == rpsr_pkg::NB_LAST) && (cj == rpsr_pkg::NB_LAST));
  assign emit    = pt_valid && cfg.render_pass && load;
  assign track   = pt_valid && !cfg.render_pass;
  assign pt_ready = cfg.render_pass ? (load && last_nb) : 1'b1;

  // neighbour offsets -1..1 in mask mode, none otherwise
  assign dx = cfg.mask_only ? (EXT_W'(ci) - EXT_W'(1)) : '0;
  assign dy = cfg.mask_only ? (EXT_W'(cj) - EXT_W'(1)) : '0;
  assign d  = cfg.mask_only ? EXT_W'(1) : '0;

  assign nb_x_ext = rpsr_pkg::sat_ext(EXT_W'(pt_x) + dx, COORD_BITS);
  assign nb_y_ext = rpsr_pkg::sat_ext(EXT_W'(pt_y) + dy, COORD_BITS);
  assign nb_x = nb_x_ext[COORD_BITS-1:0];
  assign nb_y = nb_y_ext[COORD_BITS-1:0];

  // box extremes of the whole neighbourhood
  assign hx_ext = rpsr_pkg::sat_ext(EXT_W'(pt_x) + d, COORD_BITS);
  assign lx_ext = rpsr_pkg::sat_ext(EXT_W'(pt_x) - d, COORD_BITS);
  assign hy_ext = rpsr_pkg::sat_ext(EXT_W'(pt_y) + d, COORD_BITS);
  assign ly_ext = rpsr_pkg::sat_ext(EXT_W'(pt_y) - d, COORD_BITS);
  assign cand_hi_x = hx_ext[COORD_BITS-1:0];
  assign cand_lo_x = lx_ext[COORD_BITS-1:0];
  assign cand_hi_y = hy_ext[COORD_BITS-1:0];
  assign cand_lo_y = ly_ext[COORD_BITS-1:0];

  assign col = CW'(nb_x) - CW'(lo_x);
  assign row = CW'(nb_y) - CW'(lo_y);
  assign w   = box_empty ? '0 : CW'(CW'(hi_x) - CW'(lo_x) + CW'(1));
  assign h   = box_empty ? '0 : CW'(CW'(hi_y) - CW'(lo_y) + CW'(1));
  assign outside = box_empty || col[CW-1] || row[CW-1] ||
                   ($unsigned(col) >= w) || ($unsigned(row) >= h);

  assign col_ext  = EXT_W'(col);
  assign row_ext  = EXT_W'(row);
  assign w_ext    = EXT_W'(w);
  assign h_ext    = EXT_W'(h);
  assign lo_x_ext = EXT_W'(lo_x);
  assign lo_y_ext = EXT_W'(lo_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      ci <= '0;
      cj <= '0;
    end else if (emit) begin
      if (last_nb) begin
        ci <= '0;
        cj <= '0;
      end else if (cj == rpsr_pkg::NB_LAST) begin
        ci <= ci + rpsr_pkg::NB_W'(1);
        cj <= '0;
      end else begin
        cj <= cj + rpsr_pkg::NB_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_x      <= '0;
      hi_x      <= '0;
      lo_y      <= '0;
      hi_y      <= '0;
      box_empty <= 1'b1;
    end else if (track) begin
      if (box_empty || cand_hi_x > hi_x) begin
        hi_x <= cand_hi_x;
      end
      if (box_empty || cand_lo_x < lo_x) begin
        lo_x <= cand_lo_x;
      end
      if (box_empty || cand_hi_y > hi_y) begin
        hi_y <= cand_hi_y;
      end
      if (box_empty || cand_lo_y < lo_y) begin
        lo_y <= cand_lo_y;
      end
      box_empty <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_col     <= col_ext[rpsr_pkg::PIX_W-1:0];
      pixel_row     <= row_ext[rpsr_pkg::PIX_W-1:0];
      out_rgb       <= pt_rgb;
      outside_sheet <= outside;
      last_of_point <= last_nb;
      box_min_x     <= lo_x_ext[rpsr_pkg::BOX_W-1:0];
      box_min_y     <= lo_y_ext[rpsr_pkg::BOX_W-1:0];
      sheet_width   <= w_ext[rpsr_pkg::PIX_W-1:0];
      sheet_height  <= h_ext[rpsr_pkg::PIX_W-1:0];
    end
  end

  a_single_pixel_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_point |-> cfg.mask_only)
    else $error("non-final pixel outside mask mode");

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    !box_empty |-> (lo_x <= hi_x) && (lo_y <= hi_y))
    else $error("bounding box min above max");

  a_walk_idle: assert property (@(posedge clk) disable iff (rst)
    !pt_valid |-> (ci == '0) && (cj == '0))
    else $error("neighbour walk left mid-point");

  a_render_keeps_box: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && cfg.render_pass && $past(cfg.render_pass)
      |-> $stable(lo_x) && $stable(hi_x) && $stable(lo_y) && $stable(hi_y) &&
          $stable(box_empty))
    else $error("bounding box changed while rendering");

endmodule

`default_nettype wire

@@ hdl/rotated_point_splat_renderer.sv @@
// rotated_point_splat_renderer: top level with configuration registers and the
// three pipeline parts rpsr_front, rpsr_point and rpsr_emit. Uses rpsr_pkg.
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+---------------------------
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data    | register write, always ready
//   in      | in_valid in_ready sheet_x .. blue         | one surface point
//   out     | out_valid out_ready pixel_col .. height   | one rendered pixel
//
// Registers: input, product, position and result, in that order. A point per
// cycle is taken in bounding-box mode, and in plain render mode while out_ready
// does not stall; mask_only in render mode holds each point in the position
// register until all nine of its pixels are emitted.
// Reset (rst, synchronous) clears all valids, returns the configuration to its defaults and empties the box.
// An out_ready stall backs up stage by stage until in_ready drops.
`default_nettype none

module rotated_point_splat_renderer #(
  parameter int COORD_BITS = rpsr_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rpsr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rpsr_pkg::CFG_DAT_W-1:0]        cfg_data,
  // points in
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [rpsr_pkg::SHEET_W-1:0]   sheet_x,
  input  logic signed [rpsr_pkg::SHEET_W-1:0]   sheet_y,
  input  logic [rpsr_pkg::VOL_W-1:0]            vol_x,
  input  logic [rpsr_pkg::VOL_W-1:0]            vol_z,
  input  logic [rpsr_pkg::VOL_W-1:0]            voxel,
  input  logic [rpsr_pkg::CHAN_W-1:0]           red,
  input  logic [rpsr_pkg::CHAN_W-1:0]           green,
  input  logic [rpsr_pkg::CHAN_W-1:0]           blue,
  // pixels out
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [rpsr_pkg::PIX_W-1:0]     pixel_col,
  output logic signed [rpsr_pkg::PIX_W-1:0]     pixel_row,
  output logic [rpsr_pkg::CHAN_W-1:0]           out_red,
  output logic [rpsr_pkg::CHAN_W-1:0]           out_green,
  output logic [rpsr_pkg::CHAN_W-1:0]           out_blue,
  output logic                                  outside_sheet,
  output logic                                  last_of_point,
  output logic signed [rpsr_pkg::BOX_W-1:0]     box_min_x,
  output logic signed [rpsr_pkg::BOX_W-1:0]     box_min_y,
  output logic [rpsr_pkg::PIX_W-1:0]            sheet_width,
  output logic [rpsr_pkg::PIX_W-1:0]            sheet_height
);

  rpsr_pkg::cfg_t               cfg;
  logic                         prod_valid;
  logic                         prod_ready;
  rpsr_pkg::prod_t              prod;
  logic                         pt_valid;
  logic                         pt_ready;
  logic signed [COORD_BITS-1:0] pt_x;
  logic signed [COORD_BITS-1:0] pt_y;
  rpsr_pkg::rgb_t               pt_rgb;
  rpsr_pkg::rgb_t               out_rgb;
  logic [rpsr_pkg::PIX_W-1:0]   col_bits;
  logic [rpsr_pkg::PIX_W-1:0]   row_bits;
  logic [rpsr_pkg::BOX_W-1:0]   min_x_bits;
  logic [rpsr_pkg::BOX_W-1:0]   min_y_bits;

  // register writes never stall; indexes past the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.render_pass <= 1'b0;
      cfg.mask_only   <= 1'b0;
      cfg.offset_x    <= '0;
      cfg.offset_y    <= '0;
      cfg.cos_q       <= rpsr_pkg::COS_RESET;
      cfg.sin_q       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rpsr_pkg::REG_RENDER_PASS: cfg.render_pass <= cfg_data[0];
        rpsr_pkg::REG_MASK_ONLY:   cfg.mask_only   <= cfg_data[0];
        rpsr_pkg::REG_OFFSET_X:    cfg.offset_x    <= cfg_data;
        rpsr_pkg::REG_OFFSET_Y:    cfg.offset_y    <= cfg_data;
        rpsr_pkg::REG_COS_Q:       cfg.cos_q       <= cfg_data[rpsr_pkg::TRIG_W-1:0];
        rpsr_pkg::REG_SIN_Q:       cfg.sin_q       <= cfg_data[rpsr_pkg::TRIG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register, rotation products, colour scaling
  rpsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sheet_x    (sheet_x),
    .sheet_y    (sheet_y),
    .vol_x      (vol_x),
    .vol_z      (vol_z),
    .voxel      (voxel),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod)
  );

  // offset, rounding and saturation of the position; tints and clamp
  rpsr_point #(
    .COORD_BITS (COORD_BITS)
  ) u_point (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod),
    .pt_valid   (pt_valid),
    .pt_ready   (pt_ready),
    .pt_x       (pt_x),
    .pt_y       (pt_y),
    .pt_rgb     (pt_rgb)
  );

  // box tracking or pixel emission, result register
  rpsr_emit #(
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .pt_valid      (pt_valid),
    .pt_ready      (pt_ready),
    .pt_x          (pt_x),
    .pt_y          (pt_y),
    .pt_rgb        (pt_rgb),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_col     (col_bits),
    .pixel_row     (row_bits),
    .out_rgb       (out_rgb),
    .outside_sheet (outside_sheet),
    .last_of_point (last_of_point),
    .box_min_x     (min_x_bits),
    .box_min_y     (min_y_bits),
    .sheet_width   (sheet_width),
    .sheet_height  (sheet_height)
  );

  assign pixel_col = col_bits;
  assign pixel_row = row_bits;
  assign box_min_x = min_x_bits;
  assign box_min_y = min_y_bits;
  assign out_red   = out_rgb.red;
  assign out_green = out_rgb.green;
  assign out_blue  = out_rgb.blue;

endmodule

`default_nettype wire
